// ===== hw/rtl/sbpp_pkg.sv =====
`default_nettype none

package sbpp_pkg;

   localparam int BINS_PER_FRAME = 1024;
   localparam int BAND_COUNT     = 10;
   localparam int EDGE_COUNT     = BAND_COUNT + 1;

   localparam int BIN_W      = $clog2(BINS_PER_FRAME);
   localparam int LEVEL_W    = 16;
   localparam int FRAME_W    = 16;
   localparam int POS_W      = 9;
   localparam int SUM_W      = LEVEL_W + 5;
   localparam int BAND_IDX_W = $clog2(BAND_COUNT);
   localparam int EDGE_IDX_W = $clog2(EDGE_COUNT + 1);

   localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(BINS_PER_FRAME - 1);

   typedef enum logic [1:0] {
      OP_TRACK,
      OP_ACC,
      OP_TEST
   } alu_op_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] res;
      logic                    flag;
   } alu_out_type;

   typedef struct packed {
      logic                        en;
      logic [BAND_IDX_W-1:0]       addr;
      logic signed [LEVEL_W-1:0]   level;
      logic [POS_W-1:0]            pos;
   } store_wr_type;

   // Lower edge of each band; the last entry closes the top band.
   function automatic logic [POS_W-1:0] band_edge(input logic [EDGE_IDX_W-1:0] idx);
      logic [POS_W-1:0] e;
      unique case (idx)
         4'd0:    e = 9'd100;
         4'd1:    e = 9'd105;
         4'd2:    e = 9'd110;
         4'd3:    e = 9'd117;
         4'd4:    e = 9'd130;
         4'd5:    e = 9'd150;
         4'd6:    e = 9'd180;
         4'd7:    e = 9'd220;
         4'd8:    e = 9'd300;
         4'd9:    e = 9'd400;
         4'd10:   e = 9'd500;
         default: e = 9'd500;
      endcase
      return e;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sbpp_alu.sv =====
`default_nettype none

// Shared add/compare unit for tracking, summing and the mean test.
module sbpp_alu (
   input  sbpp_pkg::alu_op_type                       op,
   input  logic signed [sbpp_pkg::LEVEL_W-1:0]        lvl_a,
   input  logic signed [sbpp_pkg::LEVEL_W-1:0]        lvl_b,
   input  logic signed [sbpp_pkg::SUM_W-1:0]          acc,
   output sbpp_pkg::alu_out_type                      result
);

   localparam int EXT_W = sbpp_pkg::SUM_W - sbpp_pkg::LEVEL_W;

   logic signed [sbpp_pkg::SUM_W-1:0] a_ext;
   logic signed [sbpp_pkg::SUM_W-1:0] b_ext;
   logic signed [sbpp_pkg::SUM_W-1:0] opnd_a;
   logic signed [sbpp_pkg::SUM_W-1:0] opnd_b;
   logic signed [sbpp_pkg::SUM_W-1:0] cmp_val;
   logic signed [sbpp_pkg::SUM_W-1:0] total;
   logic                              gt;
   logic                              eq;

   assign a_ext = {{EXT_W{lvl_a[sbpp_pkg::LEVEL_W-1]}}, lvl_a};
   assign b_ext = {{EXT_W{lvl_b[sbpp_pkg::LEVEL_W-1]}}, lvl_b};

   always_comb begin
      unique case (op)
         sbpp_pkg::OP_TRACK: begin
            opnd_a  = a_ext;
            opnd_b  = '0;
            cmp_val = b_ext;
         end
         sbpp_pkg::OP_ACC: begin
            opnd_a  = acc;
            opnd_b  = b_ext;
            cmp_val = '0;
         end
         sbpp_pkg::OP_TEST: begin
            // ten times the peak as 8x + 2x
            opnd_a  = b_ext <<< 3;
            opnd_b  = b_ext <<< 1;
            cmp_val = acc;
         end
         default: begin
            opnd_a  = '0;
            opnd_b  = '0;
            cmp_val = '0;
         end
      endcase
   end

   assign total = opnd_a + opnd_b;
   assign gt    = total > cmp_val;
   assign eq    = total == cmp_val;

   assign result.res  = total;
   assign result.flag = (op == sbpp_pkg::OP_TEST) ? gt : (gt | eq);

endmodule

`default_nettype wire

// ===== hw/rtl/sbpp_band_store.sv =====
`default_nettype none

// Per-band peak level and bin, one write and one read port.
module sbpp_band_store (
   input  logic                                   clock,
   input  sbpp_pkg::store_wr_type                 wr,
   input  logic [sbpp_pkg::BAND_IDX_W-1:0]        rd_addr,
   output logic signed [sbpp_pkg::LEVEL_W-1:0]    rd_level,
   output logic [sbpp_pkg::POS_W-1:0]             rd_pos
);

   logic signed [sbpp_pkg::LEVEL_W-1:0] level_ff [sbpp_pkg::BAND_COUNT];
   logic [sbpp_pkg::POS_W-1:0]          pos_ff   [sbpp_pkg::BAND_COUNT];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         level_ff[wr.addr] <= wr.level;
         pos_ff[wr.addr]   <= wr.pos;
      end
   end

   assign rd_level = level_ff[rd_addr];
   assign rd_pos   = pos_ff[rd_addr];

endmodule

`default_nettype wire

// ===== hw/rtl/spectral_band_peak_picker.sv =====
// Channel   Ports                                              Direction  Moves
// req       req_valid, req_stall, req_bin_level                in         one bin level
// rsp       rsp_valid, rsp_stall, rsp_frame_number,            out        one band peak
//           rsp_peak_bin, rsp_last_peak
//
// Bins are taken one per cycle while a frame streams in; the band compare
// runs on the shared add/compare unit against the band store in that cycle.
// After the last bin the same unit sums the ten peaks, tests each peak
// against the sum and then, if any band is marked, steps through the bands
// one per cycle, emitting each hit and holding on a hit while rsp is stalled.
// Reset is synchronous; req_stall is high outside the bin-tracking phase.
// The rsp register holds a transaction under stall while tracking resumes.
`default_nettype none

module spectral_band_peak_picker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [sbpp_pkg::LEVEL_W-1:0]   req_bin_level,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [sbpp_pkg::FRAME_W-1:0]          rsp_frame_number,
   output logic [sbpp_pkg::POS_W-1:0]            rsp_peak_bin,
   output logic                                  rsp_last_peak
);

   typedef enum logic [1:0] {
      ST_TRACK,
      ST_SUM,
      ST_TEST,
      ST_EMIT
   } state_type;

   localparam int BIN_W      = sbpp_pkg::BIN_W;
   localparam int BAND_IDX_W = sbpp_pkg::BAND_IDX_W;
   localparam int EDGE_IDX_W = sbpp_pkg::EDGE_IDX_W;
   localparam int BAND_COUNT = sbpp_pkg::BAND_COUNT;

   state_type                              state_ff,    state_in;
   logic [BIN_W-1:0]                       bin_ff,      bin_in;
   logic [EDGE_IDX_W-1:0]                  edge_ptr_ff, edge_ptr_in;
   logic [sbpp_pkg::FRAME_W-1:0]           frame_ff,    frame_in;
   logic [BAND_IDX_W-1:0]                  idx_ff,      idx_in;
   logic signed [sbpp_pkg::SUM_W-1:0]      acc_ff,      acc_in;
   logic [BAND_COUNT-1:0]                  hit_ff,      hit_in;
   logic                                   rsp_valid_ff, rsp_valid_in;
   logic [sbpp_pkg::FRAME_W-1:0]           rsp_frame_ff, rsp_frame_in;
   logic [sbpp_pkg::POS_W-1:0]             rsp_bin_ff,   rsp_bin_in;
   logic                                   rsp_last_ff,  rsp_last_in;

   logic                                   edge_pass;
   logic [EDGE_IDX_W-1:0]                  eff_ptr;
   logic                                   in_band;
   logic [BAND_IDX_W-1:0]                  track_band;
   logic [BAND_IDX_W-1:0]                  rd_addr;
   logic signed [sbpp_pkg::LEVEL_W-1:0]    rd_level;
   logic [sbpp_pkg::POS_W-1:0]             rd_pos;
   sbpp_pkg::alu_op_type                   alu_op;
   sbpp_pkg::alu_out_type                  alu_out;
   sbpp_pkg::store_wr_type                 store_wr;
   logic                                   last_bin;
   logic                                   idx_last;
   logic [BAND_COUNT-1:0]                  hit_test;
   logic [BAND_COUNT-1:0]                  hit_rest;
   logic                                   out_free;

   // Band position: count the band edges already passed. Edges rise, so at
   // most one is crossed per bin; any but the last edge opens a band.
   assign edge_pass  = (edge_ptr_ff < EDGE_IDX_W'(sbpp_pkg::EDGE_COUNT)) &&
                       (bin_ff == BIN_W'(sbpp_pkg::band_edge(edge_ptr_ff)));
   assign eff_ptr    = edge_ptr_ff + EDGE_IDX_W'(edge_pass);
   assign in_band    = (eff_ptr != '0) && (eff_ptr <= EDGE_IDX_W'(BAND_COUNT));
   assign track_band = in_band ? BAND_IDX_W'(eff_ptr - EDGE_IDX_W'(1)) : '0;

   assign rd_addr  = (state_ff == ST_TRACK) ? track_band : idx_ff;
   assign last_bin = bin_ff == sbpp_pkg::LAST_BIN;
   assign idx_last = idx_ff == BAND_IDX_W'(BAND_COUNT - 1);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign hit_test = hit_ff | (BAND_COUNT'(alu_out.flag) << idx_ff);
   assign hit_rest = hit_ff & ~(BAND_COUNT'(1) << idx_ff);

   always_comb begin
      unique case (state_ff)
         ST_TRACK: alu_op = sbpp_pkg::OP_TRACK;
         ST_SUM:   alu_op = sbpp_pkg::OP_ACC;
         ST_TEST:  alu_op = sbpp_pkg::OP_TEST;
         ST_EMIT:  alu_op = sbpp_pkg::OP_TEST;
         default:  alu_op = sbpp_pkg::OP_TRACK;
      endcase
   end

   sbpp_alu u_alu (
      .op     (alu_op),
      .lvl_a  (req_bin_level),
      .lvl_b  (rd_level),
      .acc    (acc_ff),
      .result (alu_out)
   );

   // Load the band unconditionally on its first bin; later bins replace the
   // peak when at least as loud, so ties go to the later bin.
   assign store_wr.en    = (state_ff == ST_TRACK) && req_valid && in_band &&
                           (edge_pass || alu_out.flag);
   assign store_wr.addr  = track_band;
   assign store_wr.level = req_bin_level;
   assign store_wr.pos   = sbpp_pkg::POS_W'(bin_ff);

   sbpp_band_store u_store (
      .clock    (clock),
      .wr       (store_wr),
      .rd_addr  (rd_addr),
      .rd_level (rd_level),
      .rd_pos   (rd_pos)
   );

   always_comb begin
      state_in     = state_ff;
      bin_in       = bin_ff;
      edge_ptr_in  = edge_ptr_ff;
      frame_in     = frame_ff;
      idx_in       = idx_ff;
      acc_in       = acc_ff;
      hit_in       = hit_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;   // drop once taken
      rsp_frame_in = rsp_frame_ff;
      rsp_bin_in   = rsp_bin_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         ST_TRACK: begin
            if (req_valid) begin
               if (last_bin) begin
                  // frame complete: wrap the bin count and start the sum
                  bin_in      = '0;
                  edge_ptr_in = '0;
                  idx_in      = '0;
                  acc_in      = '0;
                  hit_in      = '0;
                  state_in    = ST_SUM;
               end else begin
                  bin_in      = bin_ff + BIN_W'(1);
                  edge_ptr_in = eff_ptr;
               end
            end
         end
         ST_SUM: begin
            acc_in = alu_out.res;
            if (idx_last) begin
               idx_in   = '0;
               state_in = ST_TEST;
            end else begin
               idx_in = idx_ff + BAND_IDX_W'(1);
            end
         end
         ST_TEST: begin
            // mark each band whose 10*peak beats the sum of peaks
            hit_in = hit_test;
            if (idx_last) begin
               idx_in = '0;
               if (hit_test == '0) begin
                  frame_in = frame_ff + sbpp_pkg::FRAME_W'(1);
                  state_in = ST_TRACK;
               end else begin
                  state_in = ST_EMIT;
               end
            end else begin
               idx_in = idx_ff + BAND_IDX_W'(1);
            end
         end
         ST_EMIT: begin
            if (hit_ff[idx_ff]) begin
               // hold on this band until the output register frees up
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_frame_in = frame_ff;
                  rsp_bin_in   = rd_pos;
                  rsp_last_in  = hit_rest == '0;
                  hit_in       = hit_rest;
                  if (hit_rest == '0) begin
                     idx_in   = '0;
                     frame_in = frame_ff + sbpp_pkg::FRAME_W'(1);
                     state_in = ST_TRACK;
                  end else begin
                     idx_in = idx_ff + BAND_IDX_W'(1);
                  end
               end
            end else begin
               idx_in = idx_ff + BAND_IDX_W'(1);
            end
         end
         default: state_in = ST_TRACK;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_TRACK;
         bin_ff       <= '0;
         edge_ptr_ff  <= '0;
         frame_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bin_ff       <= bin_in;
         edge_ptr_ff  <= edge_ptr_in;
         frame_ff     <= frame_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      acc_ff       <= acc_in;
      hit_ff       <= hit_in;
      rsp_frame_ff <= rsp_frame_in;
      rsp_bin_ff   <= rsp_bin_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign req_stall        = state_ff != ST_TRACK;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_frame_number = rsp_frame_ff;
   assign rsp_peak_bin     = rsp_bin_ff;
   assign rsp_last_peak    = rsp_last_ff;

   // The emit phase is entered only with at least one band marked.
   a_emit_has_hits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (hit_ff != '0))
      else $error("emit phase with empty hit mask");

   // The last bin of a frame always starts the peak sum.
   a_last_bin_sums: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && last_bin) |=> (state_ff == ST_SUM))
      else $error("last bin did not start the sum");

   // The edge pointer never runs past the closing edge.
   a_edge_ptr_range: assert property (@(posedge clock) disable iff (reset)
      edge_ptr_ff <= EDGE_IDX_W'(sbpp_pkg::EDGE_COUNT))
      else $error("band edge pointer out of range");

endmodule

`default_nettype wire
